// ===== rtl/core/cbpe_pkg.sv =====
// Shared widths, register indexes and bundle types for the cubic Bezier point evaluator.
`default_nettype none

package cbpe_pkg;

    // Coordinate and curve parameter formats.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // The parameter t carries one integer bit so that 1.0 can be written.
    localparam int T_W = FRAC_BITS + 1;
    // A weight with the factor three applied stays below 4.0.
    localparam int W_W = FRAC_BITS + 2;
    // Product of a weight (with a zero sign bit) and a signed coordinate.
    localparam int P_W = W_W + 1 + COORD_BITS;
    // Sum of four products.
    localparam int S_W = P_W + 2;

    localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;
    localparam logic signed [S_W-1:0] TRUNC_BIAS = S_W'((64'd1 << FRAC_BITS) - 64'd1);

    // Configuration register file.
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_P0_X = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_P0_Y = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_P1_X = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_P1_Y = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_P2_X = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_P2_Y = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_P3_X = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_P3_Y = IDX_W'(7);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [W_W-1:0] t_weight;

    // The four Bernstein weights of one item.
    typedef struct packed {
        t_weight w0;
        t_weight w1;
        t_weight w2;
        t_weight w3;
    } t_weights;

    // Control coordinates of one axis, start point first.
    typedef struct packed {
        t_coord p0;
        t_coord p1;
        t_coord p2;
        t_coord p3;
    } t_axis_pts;

endpackage

`default_nettype wire

// ===== rtl/core/cbpe_weights.sv =====
// Three-stage pipeline that turns the curve parameter t into the four Bernstein weights.
`default_nettype none

module cbpe_weights (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [cbpe_pkg::T_W-1:0]  i_t_frac,
    output logic                           o_valid,
    output cbpe_pkg::t_weights             o_w
);

    localparam int T_W  = cbpe_pkg::T_W;
    localparam int W_W  = cbpe_pkg::W_W;
    localparam int F    = cbpe_pkg::FRAC_BITS;

    // Stage A: saturated t and its complement u.
    logic             r_a_valid;
    logic [T_W-1:0]   r_a_t;
    logic [T_W-1:0]   r_a_u;
    logic [T_W-1:0]   n_a_t;

    always_comb begin
        if (i_t_frac > cbpe_pkg::ONE) begin
            n_a_t = cbpe_pkg::ONE;
        end else begin
            n_a_t = i_t_frac;
        end
    end

    // Stage B: squares u*u and t*t, floored back to Q.F.
    logic             r_b_valid;
    logic [T_W-1:0]   r_b_t;
    logic [T_W-1:0]   r_b_u;
    logic [T_W-1:0]   r_b_uu;
    logic [T_W-1:0]   r_b_tt;
    logic [2*T_W-1:0] prod_uu;
    logic [2*T_W-1:0] prod_tt;

    assign prod_uu = r_a_u * r_a_u;
    assign prod_tt = r_a_t * r_a_t;

    // Stage C: the four cubes, the inner two scaled by three.
    logic [2*T_W-1:0] prod_uuu;
    logic [2*T_W-1:0] prod_uut;
    logic [2*T_W-1:0] prod_ttu;
    logic [2*T_W-1:0] prod_ttt;
    logic [T_W-1:0]   cube_uut;
    logic [T_W-1:0]   cube_ttu;

    assign prod_uuu = r_b_uu * r_b_u;
    assign prod_uut = r_b_uu * r_b_t;
    assign prod_ttu = r_b_tt * r_b_u;
    assign prod_ttt = r_b_tt * r_b_t;
    assign cube_uut = prod_uut[F +: T_W];
    assign cube_ttu = prod_ttu[F +: T_W];

    cbpe_pkg::t_weights n_w;

    always_comb begin
        n_w.w0 = W_W'(prod_uuu[F +: T_W]);
        n_w.w1 = {cube_uut, 1'b0} + W_W'(cube_uut);
        n_w.w2 = {cube_ttu, 1'b0} + W_W'(cube_ttu);
        n_w.w3 = W_W'(prod_ttt[F +: T_W]);
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            o_valid   <= r_b_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a_t  <= n_a_t;
        r_a_u  <= cbpe_pkg::ONE - n_a_t;
        r_b_t  <= r_a_t;
        r_b_u  <= r_a_u;
        r_b_uu <= prod_uu[F +: T_W];
        r_b_tt <= prod_tt[F +: T_W];
        o_w    <= n_w;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbpe_blend.sv =====
// Three-stage pipeline that blends the control coordinates of both axes with the weights.
`default_nettype none

module cbpe_blend (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  cbpe_pkg::t_weights        i_w,
    input  cbpe_pkg::t_axis_pts       i_pts_x,
    input  cbpe_pkg::t_axis_pts       i_pts_y,
    output logic                      o_valid,
    output cbpe_pkg::t_coord          o_point_x,
    output cbpe_pkg::t_coord          o_point_y
);

    localparam int P_W = cbpe_pkg::P_W;
    localparam int S_W = cbpe_pkg::S_W;
    localparam int F   = cbpe_pkg::FRAC_BITS;
    localparam int C   = cbpe_pkg::COORD_BITS;

    cbpe_pkg::t_axis_pts pts [2];

    assign pts[0] = i_pts_x;
    assign pts[1] = i_pts_y;

    logic                    r_m_valid;
    logic signed [P_W-1:0]   r_m_prod [2][4];
    logic                    r_s_valid;
    logic signed [S_W-1:0]   r_s_sum  [2];
    logic signed [P_W-1:0]   n_prod   [2][4];
    logic signed [S_W-1:0]   n_sum    [2];
    logic signed [S_W-1:0]   biased   [2];
    logic signed [S_W-1:0]   shifted  [2];

    // Stage M: one weight times one coordinate per multiplier.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_prod[a][0] = $signed({1'b0, i_w.w0}) * pts[a].p0;
            n_prod[a][1] = $signed({1'b0, i_w.w1}) * pts[a].p1;
            n_prod[a][2] = $signed({1'b0, i_w.w2}) * pts[a].p2;
            n_prod[a][3] = $signed({1'b0, i_w.w3}) * pts[a].p3;
        end
    end

    // Stage S: exact weighted sum of the four products.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_sum[a] = S_W'(r_m_prod[a][0]) + S_W'(r_m_prod[a][1])
                     + S_W'(r_m_prod[a][2]) + S_W'(r_m_prod[a][3]);
        end
    end

    // Output stage: divide by one, truncating toward zero.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (r_s_sum[a][S_W-1]) begin
                biased[a] = r_s_sum[a] + cbpe_pkg::TRUNC_BIAS;
            end else begin
                biased[a] = r_s_sum[a];
            end
            shifted[a] = biased[a] >>> F;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_m_valid <= i_valid;
            r_s_valid <= r_m_valid;
            o_valid   <= r_s_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_m_prod  <= n_prod;
        r_s_sum   <= n_sum;
        o_point_x <= shifted[0][C-1:0];
        o_point_y <= shifted[1][C-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/cubic_bezier_point_eval.sv =====
// Top level of the cubic Bezier point evaluator: control point registers and the pipeline.
`default_nettype none

// Evaluates one point of a cubic Bezier curve for each curve parameter t
// (unsigned Q1.16, values above 1.0 saturate to 1.0). The block takes one item
// in every clock cycle and never raises busy; each point appears on the output
// ports for one cycle with o_strobe once its item has passed through
// three stages forming the Bernstein weights and three stages multiplying,
// summing and truncating toward zero. Results come back in item order and
// the receiver must take each one in the cycle it is shown. The control points
// are written through the register port and may only change while no item is
// in flight.
module cubic_bezier_point_eval (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [cbpe_pkg::T_W-1:0]         i_t_frac,
    input  wire logic                             i_cfg_we,
    input  wire logic [cbpe_pkg::IDX_W-1:0]       i_cfg_idx,
    input  wire logic [cbpe_pkg::COORD_BITS-1:0]  i_cfg_data,
    output logic                                  o_strobe,
    output cbpe_pkg::t_coord                      o_point_x,
    output cbpe_pkg::t_coord                      o_point_y
);

    cbpe_pkg::t_coord    r_p [cbpe_pkg::NUM_REGS];
    cbpe_pkg::t_axis_pts pts_x;
    cbpe_pkg::t_axis_pts pts_y;
    cbpe_pkg::t_weights  weights;
    logic                w_valid;
    logic                accept;

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Control point registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cbpe_pkg::NUM_REGS; i++) begin
                r_p[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_p[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign pts_x.p0 = r_p[cbpe_pkg::REG_P0_X];
    assign pts_x.p1 = r_p[cbpe_pkg::REG_P1_X];
    assign pts_x.p2 = r_p[cbpe_pkg::REG_P2_X];
    assign pts_x.p3 = r_p[cbpe_pkg::REG_P3_X];
    assign pts_y.p0 = r_p[cbpe_pkg::REG_P0_Y];
    assign pts_y.p1 = r_p[cbpe_pkg::REG_P1_Y];
    assign pts_y.p2 = r_p[cbpe_pkg::REG_P2_Y];
    assign pts_y.p3 = r_p[cbpe_pkg::REG_P3_Y];

    // Weight pipeline.
    cbpe_weights u_weights (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_t_frac (i_t_frac),
        .o_valid  (w_valid),
        .o_w      (weights)
    );

    // Blend pipeline for both axes.
    cbpe_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid),
        .i_w       (weights),
        .i_pts_x   (pts_x),
        .i_pts_y   (pts_y),
        .o_valid   (o_strobe),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y)
    );

endmodule

`default_nettype wire

// ===== tb/sv/cubic_bezier_point_eval_tb.sv =====
// Self-checking testbench for the cubic Bezier point evaluator.
`default_nettype none

module cubic_bezier_point_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int T_W        = cbpe_pkg::T_W;
    localparam int IDX_W      = cbpe_pkg::IDX_W;
    localparam int COORD_BITS = cbpe_pkg::COORD_BITS;
    localparam int FRAC_BITS  = cbpe_pkg::FRAC_BITS;
    localparam logic [T_W-1:0] ONE = cbpe_pkg::ONE;

    // Start-to-strobe latency of the block, added as margin when draining.
    localparam int POINT_LATENCY = 6;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int IDLE_PERCENT  = 11;
    localparam int MAX_REPORTS   = 200;
    // Far beyond the slowest correct run.
    localparam longint TIMEOUT_NS = 64'd2_400_000;

    localparam cbpe_pkg::t_coord COORD_MIN = 12'sh800;
    localparam cbpe_pkg::t_coord COORD_MAX = 12'sh7FF;

    // One expected curve point.
    typedef struct {
        cbpe_pkg::t_coord x;
        cbpe_pkg::t_coord y;
    } t_point;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [T_W-1:0]        i_t_frac;
    logic                  i_cfg_we;
    logic [IDX_W-1:0]      i_cfg_idx;
    logic [COORD_BITS-1:0] i_cfg_data;
    logic                  o_strobe;
    cbpe_pkg::t_coord      o_point_x;
    cbpe_pkg::t_coord      o_point_y;

    // Control point mirror used by the predictor.
    cbpe_pkg::t_axis_pts curve_x;
    cbpe_pkg::t_axis_pts curve_y;

    t_point pending_points[$];
    int     mismatch_count = 0;
    bit     idle_on = 1'b1;

    cubic_bezier_point_eval dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_t_frac   (i_t_frac),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // One Bernstein factor: each product is floored back to Q0.FRAC_BITS.
    function automatic longint bern_term(longint a, longint b, longint c);
        return (((a * b) >> FRAC_BITS) * c) >> FRAC_BITS;
    endfunction

    // Weighted sum of one axis, divided by 1.0 and truncated toward zero.
    function automatic cbpe_pkg::t_coord axis_blend(cbpe_pkg::t_axis_pts pts, longint w0,
                                                    longint w1, longint w2, longint w3);
        longint sum;
        sum = w0 * longint'($signed(pts.p0)) + w1 * longint'($signed(pts.p1))
            + w2 * longint'($signed(pts.p2)) + w3 * longint'($signed(pts.p3));
        return cbpe_pkg::t_coord'(sum / (longint'(1) << FRAC_BITS));
    endfunction

    // Curve point for one parameter value under the current control points.
    function automatic t_point bezier_point(logic [T_W-1:0] t_in);
        longint one_v;
        longint t;
        longint u;
        longint w0, w1, w2, w3;
        t_point pt;
        one_v = longint'(1) << FRAC_BITS;
        t = longint'(t_in);
        // Parameters above 1.0 saturate.
        if (t > one_v) begin
            t = one_v;
        end
        u  = one_v - t;
        w0 = bern_term(u, u, u);
        w1 = 3 * bern_term(u, u, t);
        w2 = 3 * bern_term(t, t, u);
        w3 = bern_term(t, t, t);
        pt.x = axis_blend(curve_x, w0, w1, w2, w3);
        pt.y = axis_blend(curve_y, w0, w1, w2, w3);
        return pt;
    endfunction

    task automatic report_mismatch(string what, longint exp_v, longint got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH at %0t ns: %s, expected %0d, got %0d",
                     $realtime, what, exp_v, got_v);
        end
    endtask

    // Every strobe is checked against the oldest expected point.
    always @(posedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n && o_strobe) begin
            if (pending_points.size() == 0) begin
                report_mismatch("point with no item waiting", 0, o_point_x);
            end else begin
                exp_pt = pending_points.pop_front();
                if (o_point_x !== exp_pt.x) begin
                    report_mismatch("point_x", exp_pt.x, o_point_x);
                end
                if (o_point_y !== exp_pt.y) begin
                    report_mismatch("point_y", exp_pt.y, o_point_y);
                end
            end
        end
    end

    // Sends one item, with random idle cycles ahead of it when enabled.
    task automatic send_point(logic [T_W-1:0] t_val);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            start    <= 1'b0;
            i_t_frac <= T_W'($urandom);
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_t_frac <= t_val;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_points.push_back(bezier_point(t_val));
    endtask

    // Stops sending and waits until every expected point has been checked.
    task automatic wait_points_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (POINT_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, cbpe_pkg::t_coord val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        unique case (idx)
            cbpe_pkg::REG_P0_X: curve_x.p0 = val;
            cbpe_pkg::REG_P0_Y: curve_y.p0 = val;
            cbpe_pkg::REG_P1_X: curve_x.p1 = val;
            cbpe_pkg::REG_P1_Y: curve_y.p1 = val;
            cbpe_pkg::REG_P2_X: curve_x.p2 = val;
            cbpe_pkg::REG_P2_Y: curve_y.p2 = val;
            cbpe_pkg::REG_P3_X: curve_x.p3 = val;
            cbpe_pkg::REG_P3_Y: curve_y.p3 = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Loads all eight control coordinates; the block must be idle.
    task automatic load_curve(cbpe_pkg::t_axis_pts ax, cbpe_pkg::t_axis_pts ay);
        write_reg(cbpe_pkg::REG_P0_X, ax.p0);
        write_reg(cbpe_pkg::REG_P0_Y, ay.p0);
        write_reg(cbpe_pkg::REG_P1_X, ax.p1);
        write_reg(cbpe_pkg::REG_P1_Y, ay.p1);
        write_reg(cbpe_pkg::REG_P2_X, ax.p2);
        write_reg(cbpe_pkg::REG_P2_Y, ay.p2);
        write_reg(cbpe_pkg::REG_P3_X, ax.p3);
        write_reg(cbpe_pkg::REG_P3_Y, ay.p3);
    endtask

    function automatic cbpe_pkg::t_coord rand_coord();
        unique case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return cbpe_pkg::t_coord'(0);
            default: return cbpe_pkg::t_coord'($urandom);
        endcase
    endfunction

    // Mostly in-range parameters, with the endpoints and saturating values mixed in.
    function automatic logic [T_W-1:0] rand_t();
        unique case ($urandom_range(0, 19))
            0: begin
                unique case ($urandom_range(0, 3))
                    0:       return T_W'(0);
                    1:       return T_W'(1);
                    2:       return ONE - T_W'(1);
                    default: return ONE;
                endcase
            end
            1:       return ONE | T_W'($urandom_range(1, (1 << FRAC_BITS) - 1));
            2:       return T_W'($urandom);
            default: return T_W'($urandom_range(0, 1 << FRAC_BITS));
        endcase
    endfunction

    // Control points read as zero straight after reset.
    task automatic test_reset_defaults();
        send_point(ONE >> 1);
        send_point(ONE);
        wait_points_drained();
    endtask

    // Endpoints give the outer control points exactly; inner values check register mapping.
    task automatic test_endpoints();
        load_curve('{COORD_MIN, 12'sd700, -12'sd300, COORD_MAX},
                   '{COORD_MAX, -12'sd1000, 12'sd55, COORD_MIN});
        send_point(T_W'(0));
        send_point(T_W'(1));
        send_point(ONE >> 2);
        send_point(ONE >> 1);
        send_point(ONE - (ONE >> 2));
        send_point(ONE - T_W'(1));
        send_point(ONE);
        wait_points_drained();
    endtask

    // Parameters above 1.0 must behave as 1.0.
    task automatic test_saturation();
        send_point(ONE + T_W'(1));
        send_point(ONE + (ONE >> 1));
        send_point({T_W{1'b1}});
        send_point(T_W'('h1AAAA));
        send_point(T_W'('h15555));
        wait_points_drained();
    endtask

    // All control points at the most negative and most positive coordinate.
    task automatic test_extreme_coords();
        load_curve('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN},
                   '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN});
        send_point(ONE >> 1);
        send_point(T_W'(12345));
        wait_points_drained();
        load_curve('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX},
                   '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
        send_point(ONE >> 1);
        send_point(T_W'(54321));
        wait_points_drained();
    endtask

    // Several curve settings with random parameters; one phase runs without idle cycles.
    task automatic test_random_curves();
        cbpe_pkg::t_axis_pts ax, ay;
        for (int phase = 0; phase < 6; phase++) begin
            unique case (phase)
                0: begin
                    ax = '{COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX};
                    ay = '{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN};
                end
                1: begin
                    ax = '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX};
                    ay = '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN};
                end
                default: begin
                    ax = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                    ay = '{rand_coord(), rand_coord(), rand_coord(), rand_coord()};
                end
            endcase
            load_curve(ax, ay);
            idle_on = (phase != 3);
            for (int n = 0; n < 90; n++) begin
                // Once per run the sender holds off until the pipeline is empty.
                if (phase == 2 && n == 45) begin
                    wait_points_drained();
                end
                send_point(rand_t());
            end
            wait_points_drained();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_t_frac   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        curve_x    = '0;
        curve_y    = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_endpoints();
        test_saturation();
        test_extreme_coords();
        test_random_curves();

        wait_points_drained();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung pipeline or missing points.
    initial begin
        #TIMEOUT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ===== cubic_bezier_point_eval.f =====
rtl/core/cbpe_pkg.sv
rtl/core/cbpe_weights.sv
rtl/core/cbpe_blend.sv
rtl/core/cubic_bezier_point_eval.sv
tb/sv/cubic_bezier_point_eval_tb.sv
